// File: rtl/trapezoid_pulse_voltage_generator_core_assert.svh
`ifndef TRAPEZOID_PULSE_VOLTAGE_GENERATOR_CORE_ASSERT_SVH
`define TRAPEZOID_PULSE_VOLTAGE_GENERATOR_CORE_ASSERT_SVH

// same-cycle implication, off while reset is high
`define TPVG_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tpvg assertion failed");

// next-cycle implication, checked through reset
`define TPVG_ASSERT_NXT(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("tpvg assertion failed");

`endif

// File: rtl/tpvg_pkg.sv
package tpvg_pkg;

   localparam int unsigned CFG_W  = 24;
   localparam int unsigned IDX_W  = 3;
   localparam int unsigned EDGE_W = 26;
   localparam int unsigned NUM_W  = 25;
   localparam int unsigned MAG_W  = 32;
   localparam int unsigned DEN_W  = 39;
   localparam int unsigned PROD_W = 57;
   localparam int unsigned QUO_W  = 17;
   localparam int unsigned FRAC_W = 15;
   localparam logic [63:0] PI_Q30 = 64'd3373259426;

   // ceil(2^RCP_SH / ((2n)(2n+1))); exact floor division for terms below 2^32
   localparam int unsigned RCP_SH = 41;
   localparam logic [63:0] TERM_RCP [10] = '{
      ((64'd1 << RCP_SH) + 64'd5) / 64'd6,
      ((64'd1 << RCP_SH) + 64'd19) / 64'd20,
      ((64'd1 << RCP_SH) + 64'd41) / 64'd42,
      ((64'd1 << RCP_SH) + 64'd71) / 64'd72,
      ((64'd1 << RCP_SH) + 64'd109) / 64'd110,
      ((64'd1 << RCP_SH) + 64'd155) / 64'd156,
      ((64'd1 << RCP_SH) + 64'd209) / 64'd210,
      ((64'd1 << RCP_SH) + 64'd271) / 64'd272,
      ((64'd1 << RCP_SH) + 64'd341) / 64'd342,
      ((64'd1 << RCP_SH) + 64'd419) / 64'd420
   };

   typedef enum logic [1:0] {
      MODE_DC    = 2'd0,
      MODE_AC    = 2'd1,
      MODE_PULSE = 2'd2,
      MODE_NONE  = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      REG_MODE    = 3'd0,
      REG_PEAK    = 3'd1,
      REG_PERIOD  = 3'd2,
      REG_START   = 3'd3,
      REG_RISE    = 3'd4,
      REG_PLATEAU = 3'd5,
      REG_DECAY   = 3'd6
   } csr_reg_type;

   typedef enum logic [2:0] {
      KIND_ZERO  = 3'd0,
      KIND_ONE   = 3'd1,
      KIND_SINE  = 3'd2,
      KIND_RISE  = 3'd3,
      KIND_DECAY = 3'd4
   } kind_type;

   typedef struct packed {
      mode_type           mode;
      logic [15:0]        peak;
      logic [CFG_W-1:0]   start;
      logic [CFG_W-1:0]   rise;
      logic [CFG_W-1:0]   decay;
      logic [EDGE_W-1:0]  e1;
      logic [EDGE_W-1:0]  e2;
      logic [EDGE_W-1:0]  e3;
      logic               overrun;
   } cfg_type;

   // quarter-wave sine entry, Q15, evaluated at elaboration only
   function automatic logic [15:0] sine_entry(input int unsigned k, input int unsigned tbits);
      logic [63:0]  x;
      logic [63:0]  x2;
      logic [63:0]  term;
      logic [127:0] tp;
      logic [63:0]  v;
      longint       sum;
      x    = (PI_Q30 * 64'(k)) >> (tbits + 1);
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      for (int n = 1; n <= 10; n++) begin
         term = (term * x2) >> 30;
         tp   = 128'(term) * 128'(TERM_RCP[n-1]);
         term = 64'(tp >> RCP_SH);
         if ((n % 2) == 1) begin
            sum = sum - longint'(term);
         end else begin
            sum = sum + longint'(term);
         end
      end
      if (sum < 0) begin
         sum = 0;
      end
      v = (64'(sum) + 64'd16384) >> 15;
      if (v > 64'd32768) begin
         v = 64'd32768;
      end
      return v[15:0];
   endfunction

endpackage

// File: rtl/trapezoid_pulse_voltage_generator_core.sv
// Trapezoid / sine / DC voltage generator, one request per sample.
// Request channel: req_valid with req_time_ticks and req_cell_amplitude (Q1.15);
// taken when req_valid is high and req_stall is low.
// Response channel: rsp_valid with rsp_voltage and rsp_timing_error; taken when
// rsp_valid is high and rsp_stall is low. Responses come back in request order.
// Registers are written through csr_write_enable / csr_index / csr_write_data;
// the user must write them only while no request is in flight (not enforced).
// Throughput: one request per cycle while req_stall is low. The pipeline runs
// through the bit-per-stage time modulo / phase index divider, two waveform
// stages and the 17-stage quotient divider.
// Reset empties the pipeline and the two-entry output buffer and loads the
// register defaults (DC mode, zero peak, period 1000).
// While the receiver stalls, the output buffer fills; once both entries are
// held the whole pipeline freezes and req_stall goes high until one drains.
module trapezoid_pulse_voltage_generator_core #(
   parameter int SINE_TABLE_BITS = 10,
   parameter int TIME_BITS       = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [31:0]                 req_time_ticks,
   input  logic signed [15:0]          req_cell_amplitude,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic signed [16:0]          rsp_voltage,
   output logic                        rsp_timing_error,
   input  logic                        csr_write_enable,
   input  logic [tpvg_pkg::IDX_W-1:0]  csr_index,
   input  logic [tpvg_pkg::CFG_W-1:0]  csr_write_data
);

   localparam int CW = tpvg_pkg::CFG_W;
   localparam int EW = tpvg_pkg::EDGE_W;

   tpvg_pkg::mode_type mode_ff;
   logic [15:0]        peak_ff;
   logic [CW-1:0]      period_ff;
   logic [CW-1:0]      start_ff;
   logic [CW-1:0]      rise_ff;
   logic [CW-1:0]      plateau_ff;
   logic [CW-1:0]      decay_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= tpvg_pkg::MODE_DC;
         peak_ff    <= '0;
         period_ff  <= CW'(1000);
         start_ff   <= '0;
         rise_ff    <= CW'(1);
         plateau_ff <= '0;
         decay_ff   <= CW'(1);
      end else if (csr_write_enable) begin
         unique case (tpvg_pkg::csr_reg_type'(csr_index))
            tpvg_pkg::REG_MODE:    mode_ff    <= tpvg_pkg::mode_type'(csr_write_data[1:0]);
            tpvg_pkg::REG_PEAK:    peak_ff    <= csr_write_data[15:0];
            tpvg_pkg::REG_PERIOD:  period_ff  <= csr_write_data;
            tpvg_pkg::REG_START:   start_ff   <= csr_write_data;
            tpvg_pkg::REG_RISE:    rise_ff    <= csr_write_data;
            tpvg_pkg::REG_PLATEAU: plateau_ff <= csr_write_data;
            tpvg_pkg::REG_DECAY:   decay_ff   <= csr_write_data;
            default: ;
         endcase
      end
   end

   // derived segment edges, recomputed every cycle from the registers
   tpvg_pkg::cfg_type cfg_in;
   tpvg_pkg::cfg_type cfg_ff;
   logic [CW-1:0]     per_eff;

   assign per_eff = (period_ff == '0) ? CW'(1) : period_ff;

   always_comb begin
      cfg_in.mode    = mode_ff;
      cfg_in.peak    = peak_ff;
      cfg_in.start   = start_ff;
      cfg_in.rise    = rise_ff;
      cfg_in.decay   = decay_ff;
      cfg_in.e1      = EW'(start_ff) + EW'(rise_ff);
      cfg_in.e2      = cfg_in.e1 + EW'(plateau_ff);
      cfg_in.e3      = cfg_in.e2 + EW'(decay_ff);
      cfg_in.overrun = cfg_in.e3 >= EW'(per_eff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // pipeline
   logic                       en;
   logic                       ph_valid;
   logic [CW-1:0]              ph_phase;
   logic [SINE_TABLE_BITS+1:0] ph_idx;
   logic signed [15:0]         ph_amp;
   logic                       wv_valid;
   logic [tpvg_pkg::PROD_W-1:0] wv_prod;
   logic [tpvg_pkg::DEN_W-1:0] wv_den;
   logic                       wv_neg;
   logic                       wv_err;
   logic                       dv_valid;
   logic signed [16:0]         dv_voltage;
   logic                       dv_err;

   tpvg_phase #(
      .TIME_BITS       (TIME_BITS),
      .SINE_TABLE_BITS (SINE_TABLE_BITS)
   ) u_phase (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .in_time   (TIME_BITS'(req_time_ticks)),
      .in_amp    (req_cell_amplitude),
      .period    (per_eff),
      .out_valid (ph_valid),
      .out_phase (ph_phase),
      .out_idx   (ph_idx),
      .out_amp   (ph_amp)
   );

   tpvg_wave #(
      .SINE_TABLE_BITS (SINE_TABLE_BITS)
   ) u_wave (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .cfg       (cfg_ff),
      .in_valid  (ph_valid),
      .in_phase  (ph_phase),
      .in_idx    (ph_idx),
      .in_amp    (ph_amp),
      .out_valid (wv_valid),
      .out_prod  (wv_prod),
      .out_den   (wv_den),
      .out_neg   (wv_neg),
      .out_err   (wv_err)
   );

   tpvg_div u_div (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .in_valid    (wv_valid),
      .in_prod     (wv_prod),
      .in_den      (wv_den),
      .in_neg      (wv_neg),
      .in_err      (wv_err),
      .out_valid   (dv_valid),
      .out_voltage (dv_voltage),
      .out_err     (dv_err)
   );

   // two-entry output buffer
   logic signed [16:0] fv_ff [2];
   logic               fe_ff [2];
   logic               wr_ff;
   logic               rd_ff;
   logic [1:0]         cnt_ff;
   logic               push;
   logic               pop;

   assign en        = cnt_ff != 2'd2;
   assign push      = en && dv_valid;
   assign pop       = rsp_valid && !rsp_stall;
   assign req_stall = !en;
   assign rsp_valid = cnt_ff != 2'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) begin
            wr_ff <= !wr_ff;
         end
         if (pop) begin
            rd_ff <= !rd_ff;
         end
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fv_ff[wr_ff] <= dv_voltage;
         fe_ff[wr_ff] <= dv_err;
      end
   end

   assign rsp_voltage      = fv_ff[rd_ff];
   assign rsp_timing_error = fe_ff[rd_ff];

endmodule

// File: rtl/tpvg_phase.sv
module tpvg_phase #(
   parameter int TIME_BITS       = 32,
   parameter int SINE_TABLE_BITS = 10
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         en,
   input  logic                         in_valid,
   input  logic [TIME_BITS-1:0]         in_time,
   input  logic signed [15:0]           in_amp,
   input  logic [tpvg_pkg::CFG_W-1:0]   period,
   output logic                         out_valid,
   output logic [tpvg_pkg::CFG_W-1:0]   out_phase,
   output logic [SINE_TABLE_BITS+1:0]   out_idx,
   output logic signed [15:0]           out_amp
);

   localparam int IW = SINE_TABLE_BITS + 2;
   localparam int NS = TIME_BITS + IW;
   localparam int RW = tpvg_pkg::CFG_W;

   logic                 vld_ff [NS];
   logic [TIME_BITS-1:0] tm_ff  [NS];
   logic [RW-1:0]        rem_ff [NS];
   logic [RW-1:0]        ph_ff  [NS];
   logic [IW-1:0]        quo_ff [NS];
   logic signed [15:0]   amp_ff [NS];

   // one restoring step per stage: time bits first, then IW zero bits for the index
   for (genvar i = 0; i < NS; i++) begin : g_step
      logic                 vld_p;
      logic [TIME_BITS-1:0] tm_p;
      logic [RW-1:0]        rem_p;
      logic [RW-1:0]        ph_p;
      logic [IW-1:0]        quo_p;
      logic signed [15:0]   amp_p;
      logic [RW:0]          sft;
      logic                 ge;
      logic [RW-1:0]        rem_in;
      logic [RW-1:0]        ph_in;
      logic [IW-1:0]        quo_in;

      if (i == 0) begin : g_first
         assign vld_p = in_valid;
         assign tm_p  = in_time;
         assign rem_p = '0;
         assign ph_p  = '0;
         assign quo_p = '0;
         assign amp_p = in_amp;
      end else begin : g_next
         assign vld_p = vld_ff[i-1];
         assign tm_p  = tm_ff[i-1];
         assign rem_p = rem_ff[i-1];
         assign ph_p  = ph_ff[i-1];
         assign quo_p = quo_ff[i-1];
         assign amp_p = amp_ff[i-1];
      end

      assign sft    = {rem_p, tm_p[TIME_BITS-1]};
      assign ge     = sft >= {1'b0, period};
      assign rem_in = ge ? RW'(sft - {1'b0, period}) : sft[RW-1:0];

      if (i >= TIME_BITS) begin : g_quo
         assign quo_in = {quo_p[IW-2:0], ge};
      end else begin : g_noquo
         assign quo_in = quo_p;
      end

      if (i == TIME_BITS - 1) begin : g_ph
         assign ph_in = rem_in;
      end else begin : g_keep
         assign ph_in = ph_p;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else if (en) begin
            vld_ff[i] <= vld_p;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            tm_ff[i]  <= tm_p << 1;
            rem_ff[i] <= rem_in;
            ph_ff[i]  <= ph_in;
            quo_ff[i] <= quo_in;
            amp_ff[i] <= amp_p;
         end
      end
   end

   assign out_valid = vld_ff[NS-1];
   assign out_phase = ph_ff[NS-1];
   assign out_idx   = quo_ff[NS-1];
   assign out_amp   = amp_ff[NS-1];

endmodule

// File: rtl/tpvg_wave.sv
module tpvg_wave #(
   parameter int SINE_TABLE_BITS = 10
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         en,
   input  tpvg_pkg::cfg_type            cfg,
   input  logic                         in_valid,
   input  logic [tpvg_pkg::CFG_W-1:0]   in_phase,
   input  logic [SINE_TABLE_BITS+1:0]   in_idx,
   input  logic signed [15:0]           in_amp,
   output logic                         out_valid,
   output logic [tpvg_pkg::PROD_W-1:0]  out_prod,
   output logic [tpvg_pkg::DEN_W-1:0]   out_den,
   output logic                         out_neg,
   output logic                         out_err
);

   localparam int B  = SINE_TABLE_BITS;
   localparam int QL = 1 << B;
   localparam logic [B:0] QLV = {1'b1, {B{1'b0}}};
   localparam int NW = tpvg_pkg::NUM_W;
   localparam int EW = tpvg_pkg::EDGE_W;

   logic [15:0] rom [QL+1];

   for (genvar g = 0; g <= QL; g++) begin : g_rom
      localparam logic [15:0] ENTRY = tpvg_pkg::sine_entry(g, B);
      assign rom[g] = ENTRY;
   end

   // first stage: segment decode, sine address, peak times |amplitude|
   logic [1:0]                    quad;
   logic [B:0]                    rom_addr;
   logic [EW-1:0]                 ph_x;
   logic [15:0]                   amag;
   tpvg_pkg::kind_type            kind_in;
   logic [NW-1:0]                 num_in;

   logic                          v1_ff;
   tpvg_pkg::kind_type            kind_ff;
   logic [NW-1:0]                 num_ff;
   logic [tpvg_pkg::MAG_W-1:0]    mag_ff;
   logic                          aneg_ff;
   logic                          sneg_ff;
   logic                          err1_ff;
   logic [15:0]                   rom_q_ff;

   assign quad     = in_idx[B+1:B];
   assign rom_addr = quad[0] ? QLV - {1'b0, in_idx[B-1:0]} : {1'b0, in_idx[B-1:0]};
   assign ph_x     = EW'(in_phase);
   assign amag     = in_amp[15] ? 16'(-in_amp) : 16'(in_amp);

   always_comb begin
      unique case (cfg.mode)
         tpvg_pkg::MODE_DC: kind_in = tpvg_pkg::KIND_ONE;
         tpvg_pkg::MODE_AC: kind_in = tpvg_pkg::KIND_SINE;
         tpvg_pkg::MODE_PULSE: begin
            priority if (ph_x < EW'(cfg.start)) begin
               kind_in = tpvg_pkg::KIND_ZERO;
            end else if (ph_x < cfg.e1) begin
               kind_in = tpvg_pkg::KIND_RISE;
            end else if (ph_x < cfg.e2) begin
               kind_in = tpvg_pkg::KIND_ONE;
            end else if (ph_x < cfg.e3) begin
               kind_in = tpvg_pkg::KIND_DECAY;
            end else begin
               kind_in = tpvg_pkg::KIND_ZERO;
            end
         end
         default: kind_in = tpvg_pkg::KIND_ZERO;
      endcase
   end

   assign num_in = (kind_in == tpvg_pkg::KIND_RISE) ? NW'(ph_x - EW'(cfg.start))
                                                    : NW'(cfg.e3 - ph_x);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         kind_ff  <= kind_in;
         num_ff   <= num_in;
         mag_ff   <= 32'(cfg.peak) * 32'(amag);
         aneg_ff  <= in_amp[15];
         sneg_ff  <= quad[1];
         err1_ff  <= (cfg.mode == tpvg_pkg::MODE_PULSE) && cfg.overrun;
         rom_q_ff <= rom[rom_addr];
      end
   end

   // second stage: numerator times magnitude, divisor select
   logic [NW-1:0]                mn;
   logic [tpvg_pkg::DEN_W-1:0]   den_in;
   logic                         v2_ff;
   logic [tpvg_pkg::PROD_W-1:0]  prod_ff;
   logic [tpvg_pkg::DEN_W-1:0]   den_ff;
   logic                         neg_ff;
   logic                         err2_ff;

   always_comb begin
      unique case (kind_ff)
         tpvg_pkg::KIND_ONE: begin
            mn     = NW'(1);
            den_in = tpvg_pkg::DEN_W'(1) << tpvg_pkg::FRAC_W;
         end
         tpvg_pkg::KIND_SINE: begin
            mn     = NW'(rom_q_ff);
            den_in = tpvg_pkg::DEN_W'(1) << (2 * tpvg_pkg::FRAC_W);
         end
         tpvg_pkg::KIND_RISE: begin
            mn     = num_ff;
            den_in = {cfg.rise, {tpvg_pkg::FRAC_W{1'b0}}};
         end
         tpvg_pkg::KIND_DECAY: begin
            mn     = num_ff;
            den_in = {cfg.decay, {tpvg_pkg::FRAC_W{1'b0}}};
         end
         default: begin
            mn     = '0;
            den_in = tpvg_pkg::DEN_W'(1) << tpvg_pkg::FRAC_W;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= tpvg_pkg::PROD_W'(mag_ff) * tpvg_pkg::PROD_W'(mn);
         den_ff  <= den_in;
         neg_ff  <= aneg_ff ^ ((kind_ff == tpvg_pkg::KIND_SINE) && sneg_ff);
         err2_ff <= err1_ff;
      end
   end

   assign out_valid = v2_ff;
   assign out_prod  = prod_ff;
   assign out_den   = den_ff;
   assign out_neg   = neg_ff;
   assign out_err   = err2_ff;

endmodule

// File: rtl/tpvg_div.sv
module tpvg_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         en,
   input  logic                         in_valid,
   input  logic [tpvg_pkg::PROD_W-1:0]  in_prod,
   input  logic [tpvg_pkg::DEN_W-1:0]   in_den,
   input  logic                         in_neg,
   input  logic                         in_err,
   output logic                         out_valid,
   output logic signed [16:0]           out_voltage,
   output logic                         out_err
);

   localparam int QW = tpvg_pkg::QUO_W;
   localparam int PW = tpvg_pkg::PROD_W;
   localparam int DW = tpvg_pkg::DEN_W;

   logic          vld_ff [QW];
   logic [PW-1:0] rem_ff [QW];
   logic [DW-1:0] den_ff [QW];
   logic [QW-1:0] quo_ff [QW];
   logic          neg_ff [QW];
   logic          err_ff [QW];

   // quotient is known to stay below 2^QW, one bit per stage from the top
   for (genvar j = 0; j < QW; j++) begin : g_bit
      logic          vld_p;
      logic [PW-1:0] rem_p;
      logic [DW-1:0] den_p;
      logic [QW-1:0] quo_p;
      logic          neg_p;
      logic          err_p;
      logic [PW-1:0] dsh;
      logic          ge;

      if (j == 0) begin : g_first
         assign vld_p = in_valid;
         assign rem_p = in_prod;
         assign den_p = in_den;
         assign quo_p = '0;
         assign neg_p = in_neg;
         assign err_p = in_err;
      end else begin : g_next
         assign vld_p = vld_ff[j-1];
         assign rem_p = rem_ff[j-1];
         assign den_p = den_ff[j-1];
         assign quo_p = quo_ff[j-1];
         assign neg_p = neg_ff[j-1];
         assign err_p = err_ff[j-1];
      end

      assign dsh = PW'(den_p) << (QW - 1 - j);
      assign ge  = rem_p >= dsh;

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[j] <= 1'b0;
         end else if (en) begin
            vld_ff[j] <= vld_p;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[j] <= ge ? rem_p - dsh : rem_p;
            den_ff[j] <= den_p;
            quo_ff[j] <= {quo_p[QW-2:0], ge};
            neg_ff[j] <= neg_p;
            err_ff[j] <= err_p;
         end
      end
   end

   assign out_valid   = vld_ff[QW-1];
   assign out_voltage = neg_ff[QW-1] ? -signed'(quo_ff[QW-1]) : signed'(quo_ff[QW-1]);
   assign out_err     = err_ff[QW-1];

endmodule

// File: rtl/tpvg_checker.sv
`include "trapezoid_pulse_voltage_generator_core_assert.svh"

module tpvg_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_stall,
   input logic                        rsp_valid,
   input logic                        rsp_stall,
   input logic signed [16:0]          rsp_voltage,
   input logic                        rsp_timing_error
);

   `TPVG_ASSERT_NXT(a_reset_empty, clock, reset, !rsp_valid)
   `TPVG_ASSERT_IMP(a_stall_when_full, clock, reset, req_stall, rsp_valid)
   `TPVG_ASSERT_IMP(a_volt_floor, clock, reset, rsp_valid, rsp_voltage != 17'h10000)
   `TPVG_ASSERT_IMP(a_rsp_hold, clock, reset, $past(rsp_valid && rsp_stall) && !$past(reset), rsp_valid && $stable(rsp_voltage) && $stable(rsp_timing_error))

endmodule

bind trapezoid_pulse_voltage_generator_core tpvg_checker u_checker (.*);

// File: tb/tb.sv
module tb;

   localparam int LATENCY   = 63;
   localparam int WDOG_MAX  = 5000;
   localparam int QTR       = 1024;

   logic                         clock;
   logic                         reset;
   logic                         req_valid;
   logic                         req_stall;
   logic [31:0]                  req_time_ticks;
   logic signed [15:0]           req_cell_amplitude;
   logic                         rsp_valid;
   logic                         rsp_stall;
   logic signed [16:0]           rsp_voltage;
   logic                         rsp_timing_error;
   logic                         csr_write_enable;
   logic [tpvg_pkg::IDX_W-1:0]   csr_index;
   logic [tpvg_pkg::CFG_W-1:0]   csr_write_data;

   typedef struct {
      logic [16:0] voltage;
      logic        timing_error;
   } sample_exp_type;

   sample_exp_type voltage_exp_q[$];
   logic [15:0] quarter_sine [0:QTR];

   tpvg_pkg::mode_type cur_mode;
   logic [15:0] cur_peak;
   logic [23:0] cur_period, cur_start, cur_rise, cur_plateau, cur_decay;

   int  mismatches;
   int  idle_cycles;
   int  stall_left;
   int  stall_pct;
   bit  no_gaps;

   trapezoid_pulse_voltage_generator_core dut (.*);

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // truncating scale of peak*amplitude by num/(den*2^15), saturated to 17 bits
   function automatic logic [16:0] scaled_voltage(input longint pa, input longint num,
                                                  input longint unsigned den);
      longint unsigned mp, mn, q;
      longint          r;
      bit              neg;
      mp  = pa < 0 ? longint'(-pa) : pa;
      mn  = num < 0 ? longint'(-num) : num;
      neg = (pa < 0) != (num < 0);
      if (den == 0) den = 1;
      q = (mp * mn) / (den << 15);
      r = neg ? -longint'(q) : longint'(q);
      if (r > 65535) r = 65535;
      if (r < -65536) r = -65536;
      return r[16:0];
   endfunction

   function automatic sample_exp_type predict_voltage(input logic [31:0] t,
                                                      input logic signed [15:0] a);
      sample_exp_type      e;
      longint              pa;
      longint unsigned     per, ph, idx, e1, e2, e3;
      int unsigned         quad, k;
      longint              s;
      pa  = longint'(cur_peak) * longint'(a);
      per = (cur_period == 0) ? 1 : cur_period;
      ph  = longint'(t) % per;
      e.voltage      = '0;
      e.timing_error = 1'b0;
      unique case (cur_mode)
         tpvg_pkg::MODE_DC: begin
            e.voltage = scaled_voltage(pa, 1, 1);
         end
         tpvg_pkg::MODE_AC: begin
            idx  = (ph << 12) / per;
            quad = (idx >> 10) & 3;
            k    = idx & (QTR - 1);
            if (quad & 1) k = QTR - k;
            s = quarter_sine[k];
            if (quad & 2) s = -s;
            e.voltage = scaled_voltage(pa, s, 64'd1 << 15);
         end
         tpvg_pkg::MODE_PULSE: begin
            e1 = longint'(cur_start) + cur_rise;
            e2 = e1 + cur_plateau;
            e3 = e2 + cur_decay;
            e.timing_error = (e3 >= per);
            if (ph < cur_start) e.voltage = '0;
            else if (ph < e1) e.voltage = scaled_voltage(pa, ph - cur_start, cur_rise);
            else if (ph < e2) e.voltage = scaled_voltage(pa, 1, 1);
            else if (ph < e3) e.voltage = scaled_voltage(pa, e3 - ph, cur_decay);
            else e.voltage = '0;
         end
         default: ;
      endcase
      return e;
   endfunction

   task automatic write_reg(input tpvg_pkg::csr_reg_type idx, input logic [23:0] val);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= val;
      @(posedge clock);
      unique case (idx)
         tpvg_pkg::REG_MODE:    cur_mode    = tpvg_pkg::mode_type'(val[1:0]);
         tpvg_pkg::REG_PEAK:    cur_peak    = val[15:0];
         tpvg_pkg::REG_PERIOD:  cur_period  = val;
         tpvg_pkg::REG_START:   cur_start   = val;
         tpvg_pkg::REG_RISE:    cur_rise    = val;
         tpvg_pkg::REG_PLATEAU: cur_plateau = val;
         tpvg_pkg::REG_DECAY:   cur_decay   = val;
         default: ;
      endcase
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      csr_write_enable <= 1'b0;
      @(posedge clock);
      while (voltage_exp_q.size() != 0) @(posedge clock);
      repeat (LATENCY + 5) @(posedge clock);
   endtask

   task automatic set_pulse(input tpvg_pkg::mode_type m, input logic [15:0] pk,
                            input logic [23:0] per,
                            input logic [23:0] st, input logic [23:0] ri,
                            input logic [23:0] pl, input logic [23:0] de);
      drain();
      write_reg(tpvg_pkg::REG_MODE, 24'(m));
      write_reg(tpvg_pkg::REG_PEAK, 24'(pk));
      write_reg(tpvg_pkg::REG_PERIOD, per);
      write_reg(tpvg_pkg::REG_START, st);
      write_reg(tpvg_pkg::REG_RISE, ri);
      write_reg(tpvg_pkg::REG_PLATEAU, pl);
      write_reg(tpvg_pkg::REG_DECAY, de);
      csr_write_enable <= 1'b0;
   endtask

   function automatic int gap_len();
      int r;
      if (no_gaps) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   task automatic send_sample(input logic [31:0] t, input logic signed [15:0] a);
      int g;
      g = gap_len();
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_time_ticks     <= t;
      req_cell_amplitude <= a;
      do @(posedge clock); while (req_stall);
      voltage_exp_q.push_back(predict_voltage(t, a));
   endtask

   task automatic test_dc();
      set_pulse(tpvg_pkg::MODE_DC, 16'hFFFF, 24'd1000, 0, 1, 0, 1);
      send_sample(32'h0, 16'sh7FFF);
      send_sample(32'hFFFF_FFFF, -16'sd32768);
      send_sample(32'h5555_AAAA, 16'sh0001);
      send_sample(32'hAAAA_5555, -16'sd1);
      set_pulse(tpvg_pkg::MODE_DC, 16'h0000, 24'd1000, 0, 1, 0, 1);
      send_sample(32'h1234, 16'sh7FFF);
   endtask

   task automatic test_ac();
      set_pulse(tpvg_pkg::MODE_AC, 16'hFFFF, 24'd4096, 0, 1, 0, 1);
      send_sample(32'd0, 16'sh7FFF);
      send_sample(32'd1024, 16'sh7FFF);
      send_sample(32'd2048, -16'sd32768);
      send_sample(32'd3072, 16'sh7FFF);
      send_sample(32'd4095, 16'sh4000);
   endtask

   task automatic test_pulse_edges();
      int pts[12] = '{0, 9, 10, 11, 14, 15, 34, 35, 42, 43, 99, 100};
      set_pulse(tpvg_pkg::MODE_PULSE, 16'd40000, 24'd100, 24'd10, 24'd5, 24'd20, 24'd8);
      foreach (pts[i]) send_sample(pts[i], 16'sh7FFF);
   endtask

   task automatic test_corner_cfg();
      // segments overrun the period: flag raised, waveform still computed
      set_pulse(tpvg_pkg::MODE_PULSE, 16'd30000, 24'd100, 24'd50, 24'd20, 24'd20, 24'd10);
      send_sample(32'd60, 16'sh7FFF);
      send_sample(32'd95, -16'sd20000);
      // empty rise and decay, zero period
      set_pulse(tpvg_pkg::MODE_PULSE, 16'd30000, 24'd0, 24'd0, 24'd0, 24'd3, 24'd0);
      send_sample(32'd7, 16'sh7FFF);
      set_pulse(tpvg_pkg::MODE_PULSE, 16'hFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
                24'hFFFFFF, 24'hFFFFFF);
      send_sample(32'hFFFF_FFFF, 16'sh7FFF);
      set_pulse(tpvg_pkg::MODE_NONE, 16'hFFFF, 24'd100, 0, 1, 0, 1);
      send_sample(32'd5, 16'sh7FFF);
   endtask

   function automatic logic [23:0] rand_len(input int hi);
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return 24'($urandom);
      if (r == 1) return 24'd0;
      return 24'($urandom_range(1, hi));
   endfunction

   task automatic test_random();
      int          per;
      logic [15:0] pk;
      logic [31:0] t;
      for (int ph = 0; ph < 12; ph++) begin
         per = ($urandom_range(0, 5) == 0) ? $urandom : $urandom_range(1, 4000);
         pk  = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
         set_pulse(tpvg_pkg::mode_type'(ph < 2 ? ph : $urandom_range(0, 3)), pk, 24'(per),
                   rand_len(per / 4 + 1), rand_len(per / 4 + 1), rand_len(per / 4 + 1),
                   rand_len(per / 4 + 1));
         if (ph == 4) set_pulse(tpvg_pkg::MODE_PULSE, pk, 24'(per), 0, 1, 24'(per / 2), 1);
         no_gaps   = (ph % 4 == 3);
         stall_pct = (ph % 4 == 2) ? 0 : $urandom_range(5, 50);
         for (int i = 0; i < 150; i++) begin
            t = $urandom;
            if ($urandom_range(0, 1)) t = t % 32'(per + 1);
            send_sample(t, 16'($urandom));
            if (i == 75 && ph == 6) begin
               req_valid <= 1'b0;
               @(posedge clock);
               while (voltage_exp_q.size() != 0) @(posedge clock);
            end
         end
      end
      no_gaps   = 1'b0;
      stall_pct = 20;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (voltage_exp_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected response %0d", rsp_voltage);
            end else begin
               sample_exp_type e;
               e = voltage_exp_q.pop_front();
               if (rsp_voltage !== e.voltage || rsp_timing_error !== e.timing_error) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: voltage exp %0d got %0d, err exp %0b got %0b",
                              $signed(e.voltage), rsp_voltage, e.timing_error,
                              rsp_timing_error);
               end
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if ($urandom_range(0, 199) == 0 && stall_pct > 0) begin
            stall_left = $urandom_range(20, 60);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WDOG_MAX) begin
         $display("trapezoid_pulse_voltage_generator_core verification failed");
         $finish;
      end
   end

   initial begin
      longint unsigned x, x2, term, v;
      longint          sum;
      for (int k = 0; k <= QTR; k++) begin
         x    = (64'd3373259426 * k) >> 11;
         x2   = (x * x) >> 30;
         term = x;
         sum  = x;
         for (int n = 1; n <= 10; n++) begin
            term = (term * x2) >> 30;
            term = term / ((2 * n) * (2 * n + 1));
            sum  = (n % 2) ? sum - longint'(term) : sum + longint'(term);
         end
         if (sum < 0) sum = 0;
         v = (sum + 16384) >> 15;
         quarter_sine[k] = (v > 32768) ? 16'h8000 : v[15:0];
      end
      cur_mode = tpvg_pkg::MODE_DC;  cur_peak = 0;  cur_period = 1000;
      cur_start = 0;  cur_rise = 1;  cur_plateau = 0;  cur_decay = 1;
      stall_pct = 20;  no_gaps = 0;
      reset = 1'b1;  req_valid = 1'b0;  req_time_ticks = '0;  req_cell_amplitude = '0;
      csr_write_enable = 1'b0;  csr_index = '0;  csr_write_data = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_sample(32'd500, 16'sh7FFF);
      test_dc();
      test_ac();
      test_pulse_edges();
      test_corner_cfg();
      test_random();
      drain();
      if (mismatches == 0 && voltage_exp_q.size() == 0) begin
         $display("trapezoid_pulse_voltage_generator_core verification clean");
      end else begin
         $display("trapezoid_pulse_voltage_generator_core verification failed");
      end
      $finish;
   end
endmodule
